// ===== rtl/fwb_pkg.sv =====
// Package for the TCP feature window builder: beat types, the division
// descriptor passed from the front end to the back end, and shared constants.
// No dependencies.
package fwb_pkg;

   localparam int FEATURE_COUNT       = 10;
   localparam int HISTORY_FRAMES_DEF  = 4;

   localparam logic [31:0] Q_SAT  = 32'hFFFF_FFFF;
   localparam logic [31:0] Q_TWO  = 32'h0002_0000;
   localparam logic [31:0] Q_HALF = 32'h0000_8000;
   localparam logic [31:0] Q_ZERO = 32'h0000_0000;

   // 1460 bytes * 8 bits * 1e6 / 10
   localparam logic [31:0] F3_SCALE  = 32'd1168000000;
   localparam logic [63:0] F4_DIVSOR = 64'd10000000;
   localparam logic [63:0] F5_DIVSOR = 64'd500000;

   // Front end sequence: two multiply steps, then one descriptor per feature.
   localparam logic [3:0] STEP_MUL_A = 4'd0;
   localparam logic [3:0] STEP_MUL_B = 4'd1;
   localparam logic [3:0] STEP_FEAT0 = 4'd2;
   localparam logic [3:0] STEP_LAST  = 4'd11;

   localparam logic [3:0] FEAT_LAST = 4'd9;

   typedef struct packed {
      logic [31:0] avg_throughput;
      logic [31:0] avg_unsmoothed_rtt;
      logic [31:0] smoothed_rtt_x8;
      logic [31:0] minimum_rtt;
      logic [31:0] max_throughput;
      logic [31:0] congestion_window;
      logic [31:0] packets_in_flight;
      logic [31:0] pacing_rate_in;
      logic [31:0] retransmits_out;
      logic [16:0] loss_fraction;
   } req_type;

   typedef struct packed {
      logic [31:0] feature_value;
      logic [5:0]  window_position;
      logic        last_value;
   } rsp_type;

   // One Q16.16 division job: result = min(floor(num * 2^16 / den), cap),
   // or simply value when bypass is set.
   typedef struct packed {
      logic [63:0] num;
      logic [63:0] den;
      logic [31:0] cap;
      logic        bypass;
      logic [31:0] value;
   } desc_type;

endpackage

// ===== rtl/fwb_front.sv =====
// Front end of the TCP feature window builder: takes one sample beat and
// turns it into ten division descriptors. Depends on fwb_pkg.
module fwb_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  fwb_pkg::req_type req_data,
   output fwb_pkg::desc_type desc_data,
   output logic            desc_push,
   input  logic            desc_full
);
   import fwb_pkg::*;

   logic        busy_ff;
   logic [3:0]  step_ff;
   req_type     item_ff;
   logic [63:0] num3_ff;
   logic [63:0] den3_ff;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [3:0]  fidx;
   logic        mn_zero;
   logic        mx_zero;

   assign full = busy_ff;

   // One shared 32x32 multiplier, used in the first two steps for feature 3.
   assign mul_a = (step_ff == STEP_MUL_A) ? item_ff.congestion_window : item_ff.minimum_rtt;
   assign mul_b = (step_ff == STEP_MUL_A) ? F3_SCALE : item_ff.max_throughput;
   assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

   assign fidx      = step_ff - STEP_FEAT0;
   assign desc_push = busy_ff && (step_ff >= STEP_FEAT0) && !desc_full;
   assign mn_zero   = (item_ff.minimum_rtt == 32'b0);
   assign mx_zero   = (item_ff.max_throughput == 32'b0);

   always_comb begin
      desc_data.num    = 64'b0;
      desc_data.den    = 64'b0;
      desc_data.cap    = Q_SAT;
      desc_data.bypass = 1'b0;
      desc_data.value  = Q_ZERO;
      case (fidx)
         4'd0: begin
            desc_data.num = {32'b0, item_ff.avg_throughput};
            desc_data.den = {32'b0, item_ff.max_throughput};
            if (item_ff.avg_throughput == 32'b0) begin
               desc_data.bypass = 1'b1;
               desc_data.value  = Q_HALF;
            end else if (mx_zero) begin
               desc_data.bypass = 1'b1;
            end
         end
         4'd1: begin
            desc_data.num = {32'b0, item_ff.avg_unsmoothed_rtt};
            desc_data.den = {32'b0, item_ff.minimum_rtt};
            desc_data.cap = Q_TWO;
            if (item_ff.avg_unsmoothed_rtt == 32'b0) begin
               desc_data.bypass = 1'b1;
               desc_data.value  = Q_TWO;
            end else if (mn_zero) begin
               desc_data.bypass = 1'b1;
            end
         end
         4'd2: begin
            desc_data.num = {32'b0, item_ff.smoothed_rtt_x8};
            desc_data.den = {29'b0, item_ff.minimum_rtt, 3'b0};
            desc_data.cap = Q_TWO;
            if (item_ff.smoothed_rtt_x8 == 32'b0) begin
               desc_data.bypass = 1'b1;
               desc_data.value  = Q_TWO;
            end else if (mn_zero) begin
               desc_data.bypass = 1'b1;
            end
         end
         4'd3: begin
            desc_data.num    = num3_ff;
            desc_data.den    = den3_ff;
            desc_data.cap    = Q_TWO;
            desc_data.bypass = mn_zero || mx_zero;
         end
         4'd4: begin
            desc_data.num = {32'b0, item_ff.max_throughput};
            desc_data.den = F4_DIVSOR;
         end
         4'd5: begin
            desc_data.num = {32'b0, item_ff.minimum_rtt};
            desc_data.den = F5_DIVSOR;
         end
         4'd6: begin
            desc_data.num    = {47'b0, item_ff.loss_fraction};
            desc_data.den    = {16'b0, item_ff.max_throughput, 16'b0};
            desc_data.bypass = mx_zero;
         end
         4'd7: begin
            // A zero window is caught by the divider and gives the cap.
            desc_data.num = {32'b0, item_ff.packets_in_flight};
            desc_data.den = {32'b0, item_ff.congestion_window};
         end
         4'd8: begin
            desc_data.num    = {32'b0, item_ff.pacing_rate_in};
            desc_data.den    = {32'b0, item_ff.max_throughput};
            desc_data.cap    = Q_TWO;
            desc_data.bypass = mx_zero;
         end
         4'd9: begin
            desc_data.num    = {32'b0, item_ff.retransmits_out};
            desc_data.den    = {32'b0, item_ff.packets_in_flight};
            desc_data.bypass = (item_ff.packets_in_flight == 32'b0);
         end
         default: begin
            desc_data.bypass = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_MUL_A;
      end else if (!busy_ff) begin
         if (push) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_MUL_A;
         end
      end else if (step_ff < STEP_FEAT0) begin
         step_ff <= step_ff + 4'd1;
      end else if (desc_push) begin
         if (step_ff == STEP_LAST) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push && !busy_ff) begin
         item_ff <= req_data;
      end
      if (busy_ff && step_ff == STEP_MUL_A) begin
         num3_ff <= mul_p;
      end
      if (busy_ff && step_ff == STEP_MUL_B) begin
         den3_ff <= mul_p;
      end
   end

   property p_push_only_when_busy;
      @(posedge clock) disable iff (reset) desc_push |-> busy_ff;
   endproperty
   a_push_only_when_busy: assert property (p_push_only_when_busy)
      else $error("descriptor pushed while front end idle");

   property p_products_ready;
      @(posedge clock) disable iff (reset)
         (busy_ff && step_ff == STEP_MUL_B) |=> (step_ff == STEP_FEAT0);
   endproperty
   a_products_ready: assert property (p_products_ready)
      else $error("front end left multiply steps out of order");

   property p_accept_starts;
      @(posedge clock) disable iff (reset)
         (push && !busy_ff) |=> (busy_ff && step_ff == STEP_MUL_A);
   endproperty
   a_accept_starts: assert property (p_accept_starts)
      else $error("accepted sample did not start the sequence");

endmodule

// ===== rtl/fwb_queue.sv =====
// Two-entry queue of division descriptors between the front and back ends.
// Depends on fwb_pkg.
module fwb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  fwb_pkg::desc_type wr_data,
   output logic             q_full,
   input  logic             rd_en,
   output fwb_pkg::desc_type rd_data,
   output logic             q_empty
);
   import fwb_pkg::*;

   desc_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_wr;
   logic       do_rd;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/fwb_divider.sv =====
// Bit-serial Q16.16 divider with saturation and cap, one quotient bit per
// cycle. Depends on fwb_pkg.
module fwb_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  fwb_pkg::desc_type job,
   output logic             done,
   output logic [31:0]      result
);
   import fwb_pkg::*;

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_FIN  = 3'b100
   } dv_state_type;

   dv_state_type state_ff;
   logic [63:0]  rem_ff;
   logic [63:0]  den_ff;
   logic [31:0]  sh_ff;
   logic [31:0]  q_ff;
   logic [31:0]  cap_ff;
   logic [4:0]   cnt_ff;
   logic [64:0]  trial;
   logic [64:0]  diff;
   logic         sat;

   // The integer part overflows 16 bits exactly when num / 2^16 >= den.
   assign sat   = ({16'b0, job.num[63:16]} >= job.den);
   assign trial = {rem_ff, sh_ff[31]};
   assign diff  = trial - {1'b0, den_ff};

   assign done   = (state_ff == DV_FIN);
   assign result = (q_ff > cap_ff) ? cap_ff : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  cnt_ff <= 5'd31;
                  if (job.bypass || job.den == 64'b0 || sat) begin
                     state_ff <= DV_FIN;
                  end else begin
                     state_ff <= DV_RUN;
                  end
               end
            end
            DV_RUN: begin
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= DV_FIN;
               end
            end
            DV_FIN: begin
               state_ff <= DV_IDLE;
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == DV_IDLE && start) begin
         rem_ff <= {16'b0, job.num[63:16]};
         sh_ff  <= {job.num[15:0], 16'b0};
         den_ff <= job.den;
         cap_ff <= job.cap;
         if (job.bypass) begin
            q_ff   <= job.value;
            cap_ff <= job.value;
         end else begin
            // Zero divisor and overflow both resolve to the cap.
            q_ff <= Q_SAT;
         end
      end else if (state_ff == DV_RUN) begin
         sh_ff <= {sh_ff[30:0], 1'b0};
         if (!diff[64]) begin
            rem_ff <= diff[63:0];
            q_ff   <= {q_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial[63:0];
            q_ff   <= {q_ff[30:0], 1'b0};
         end
      end
   end

endmodule

// ===== rtl/fwb_back.sv =====
// Back end of the TCP feature window builder: runs each descriptor through
// the divider, stores the feature in the window memory and streams the window
// out. Depends on fwb_pkg and fwb_divider.
module fwb_back #(
   parameter int HISTORY_FRAMES = fwb_pkg::HISTORY_FRAMES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  fwb_pkg::desc_type q_data,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output fwb_pkg::rsp_type  rsp_data
);
   import fwb_pkg::*;

   localparam int WIN = HISTORY_FRAMES * FEATURE_COUNT;
   localparam int AW  = $clog2(WIN);
   localparam int FW  = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
   localparam logic [AW-1:0] LAST_BASE = AW'(WIN - FEATURE_COUNT);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WIN - 1);
   localparam logic [FW-1:0] LAST_FRM  = FW'(HISTORY_FRAMES - 1);
   localparam logic [5:0]    LAST_POS  = 6'(WIN - 1);

   typedef enum logic [2:0] {
      BK_FETCH = 3'b001,
      BK_WAIT  = 3'b010,
      BK_EMIT  = 3'b100
   } bk_state_type;

   bk_state_type      state_ff;
   logic [3:0]        feat_ff;
   logic [AW-1:0]     wr_base_ff;
   logic [FW-1:0]     wr_frm_ff;
   logic [HISTORY_FRAMES-1:0] frm_valid_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic [FW-1:0]     rd_frm_ff;
   logic [3:0]        rd_feat_ff;
   logic [5:0]        pos_ff;
   logic [AW-1:0]     next_base;
   logic [FW-1:0]     next_frm;
   logic [AW-1:0]     wr_addr;

   logic [31:0]       win_mem [WIN];
   logic [31:0]       rd_data_ff;
   logic              rd_vld_ff;
   logic [5:0]        rd_pos_ff;
   logic              rd_last_ff;
   logic              inflight_ff;

   rsp_type           ob_ff [2];
   logic              ob_wr_ff;
   logic              ob_rd_ff;
   logic [1:0]        ob_cnt_ff;
   logic [1:0]        ob_cnt_in;
   logic              ob_pop;
   logic              issue;
   logic              div_start;
   logic              div_done;
   logic [31:0]       div_result;
   logic              mem_we;

   fwb_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .job    (q_data),
      .done   (div_done),
      .result (div_result)
   );

   assign q_pop     = (state_ff == BK_FETCH) && !q_empty;
   assign div_start = q_pop;
   assign mem_we    = (state_ff == BK_WAIT) && div_done;
   assign wr_addr   = AW'(wr_base_ff + AW'(feat_ff));
   assign next_base = (wr_base_ff == LAST_BASE) ? '0 : AW'(wr_base_ff + AW'(FEATURE_COUNT));
   assign next_frm  = (wr_frm_ff == LAST_FRM) ? '0 : FW'(wr_frm_ff + FW'(1));

   assign ob_pop    = pop && !empty;
   assign empty     = (ob_cnt_ff == 2'd0);
   assign rsp_data  = ob_ff[ob_rd_ff];
   // Room check counts reads already in flight to the output buffer.
   assign issue     = (state_ff == BK_EMIT) &&
                      ((ob_cnt_ff + {1'b0, inflight_ff} - {1'b0, ob_pop}) < 2'd2);
   assign ob_cnt_in = ob_cnt_ff + {1'b0, inflight_ff} - {1'b0, ob_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_FETCH;
         feat_ff      <= 4'd0;
         wr_base_ff   <= '0;
         wr_frm_ff    <= '0;
         frm_valid_ff <= '0;
         rd_addr_ff   <= '0;
         rd_frm_ff    <= '0;
         rd_feat_ff   <= 4'd0;
         pos_ff       <= 6'd0;
      end else begin
         unique case (state_ff)
            BK_FETCH: begin
               if (q_pop) begin
                  state_ff <= BK_WAIT;
               end
            end
            BK_WAIT: begin
               if (div_done) begin
                  frm_valid_ff[wr_frm_ff] <= 1'b1;
                  if (feat_ff == FEAT_LAST) begin
                     feat_ff    <= 4'd0;
                     wr_base_ff <= next_base;
                     wr_frm_ff  <= next_frm;
                     rd_addr_ff <= next_base;
                     rd_frm_ff  <= next_frm;
                     rd_feat_ff <= 4'd0;
                     pos_ff     <= 6'd0;
                     state_ff   <= BK_EMIT;
                  end else begin
                     feat_ff  <= feat_ff + 4'd1;
                     state_ff <= BK_FETCH;
                  end
               end
            end
            BK_EMIT: begin
               if (issue) begin
                  pos_ff     <= pos_ff + 6'd1;
                  rd_addr_ff <= (rd_addr_ff == LAST_ADDR) ? '0 : AW'(rd_addr_ff + AW'(1));
                  if (rd_feat_ff == FEAT_LAST) begin
                     rd_feat_ff <= 4'd0;
                     rd_frm_ff  <= (rd_frm_ff == LAST_FRM) ? '0 : FW'(rd_frm_ff + FW'(1));
                  end else begin
                     rd_feat_ff <= rd_feat_ff + 4'd1;
                  end
                  if (pos_ff == LAST_POS) begin
                     state_ff <= BK_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= BK_FETCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[wr_addr] <= div_result;
      end
      if (issue) begin
         rd_data_ff <= win_mem[rd_addr_ff];
         rd_vld_ff  <= frm_valid_ff[rd_frm_ff];
         rd_pos_ff  <= pos_ff;
         rd_last_ff <= (pos_ff == LAST_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
         ob_wr_ff    <= 1'b0;
         ob_rd_ff    <= 1'b0;
         ob_cnt_ff   <= 2'd0;
      end else begin
         inflight_ff <= issue;
         ob_cnt_ff   <= ob_cnt_in;
         if (inflight_ff) begin
            ob_wr_ff <= ~ob_wr_ff;
         end
         if (ob_pop) begin
            ob_rd_ff <= ~ob_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (inflight_ff) begin
         // A frame never written since reset reads as zero.
         ob_ff[ob_wr_ff].feature_value   <= rd_vld_ff ? rd_data_ff : Q_ZERO;
         ob_ff[ob_wr_ff].window_position <= rd_pos_ff;
         ob_ff[ob_wr_ff].last_value      <= rd_last_ff;
      end
   end

   property p_ob_bound;
      @(posedge clock) disable iff (reset) ob_cnt_ff <= 2'd2;
   endproperty
   a_ob_bound: assert property (p_ob_bound)
      else $error("output buffer overflow");

   property p_done_in_wait;
      @(posedge clock) disable iff (reset) div_done |-> (state_ff == BK_WAIT);
   endproperty
   a_done_in_wait: assert property (p_done_in_wait)
      else $error("divider finished outside the wait state");

   property p_emit_after_last;
      @(posedge clock) disable iff (reset)
         (mem_we && feat_ff == FEAT_LAST) |=> (state_ff == BK_EMIT && pos_ff == 6'd0);
   endproperty
   a_emit_after_last: assert property (p_emit_after_last)
      else $error("window readout did not start after the tenth feature");

endmodule

// ===== rtl/tcp_feature_window_builder.sv =====
// Top level of the TCP feature window builder: front end, descriptor queue
// and back end. Depends on fwb_pkg, fwb_front, fwb_queue and fwb_back.
//
// Each accepted sample beat becomes ten Q16.16 features (ratios of the flow
// statistics, with the documented zero-divisor values and clamps), which are
// appended as the newest frame of a sliding window of HISTORY_FRAMES frames;
// the window is all zeros after reset. After every sample the whole window,
// HISTORY_FRAMES*10 beats, is streamed out oldest frame first, feature 0
// first within a frame, with its flattened position and a flag on the final
// beat. The front end first runs the multiplies for the bandwidth delay
// feature and then hands one division job per cycle, while the queue has
// room, into a two-entry queue. All divisions share one bit-serial divider,
// which produces one quotient bit per cycle; each feature passes through a
// load step, the quotient bits and a finish step, and a feature that
// bypasses the divider or saturates goes straight from load to finish. The
// next sample is taken as soon as the front end has queued the previous
// one's jobs. Results that are not taken stall the window readout, then the
// division queue, and at last the input, which then holds full high.
module tcp_feature_window_builder #(
   parameter int HISTORY_FRAMES = fwb_pkg::HISTORY_FRAMES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  fwb_pkg::req_type req_data,
   output logic            empty,
   input  logic            pop,
   output fwb_pkg::rsp_type rsp_data
);
   import fwb_pkg::*;

   desc_type front_desc;
   logic     front_push;
   logic     q_full;
   desc_type q_data;
   logic     q_empty;
   logic     q_pop;

   fwb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .desc_data (front_desc),
      .desc_push (front_push),
      .desc_full (q_full)
   );

   fwb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_desc),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .q_empty (q_empty)
   );

   fwb_back #(
      .HISTORY_FRAMES (HISTORY_FRAMES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_data),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== verif/tb_tcp_feature_window_builder.sv =====
// Self-checking testbench for the TCP feature window builder.
// Depends on fwb_pkg and tcp_feature_window_builder; a built-in predictor
// computes every window beat, a directed table runs first, then random samples.
`timescale 1ns / 100ps

module tb_tcp_feature_window_builder;
   import fwb_pkg::*;

   localparam int FRAMES      = HISTORY_FRAMES_DEF;
   localparam int WINDOW_LEN  = FRAMES * FEATURE_COUNT;
   localparam int RANDOM_ITEMS = 163;
   localparam int STALL_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   tcp_feature_window_builder #(.HISTORY_FRAMES(FRAMES)) u_top (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Predictor state: the sliding window as the block should hold it.
   logic [31:0] window_model [WINDOW_LEN];
   // Window beats still to come, oldest first.
   rsp_type     pending_beats [$];
   int          mismatch_count;
   bit          stim_done;
   bit          hold_off;

   // A directed row: the sample plus, where obvious, the ten features of it.
   typedef struct {
      req_type     sample;
      bit          has_expected;
      logic [31:0] features [FEATURE_COUNT];
   } row_type;

   row_type directed_rows [$];

   // Q16.16 quotient floor(num*2^16/den), saturated, then limited to cap.
   // A zero divisor yields cap.
   function automatic logic [31:0] q16_quotient(logic [63:0] num, logic [63:0] den,
                                                logic [31:0] cap);
      logic [63:0]  whole;
      logic [127:0] wide;
      logic [31:0]  value;
      if (den == 0)
         return cap;
      whole = num / den;
      if (whole > 64'hFFFF) begin
         value = Q_SAT;
      end else begin
         wide  = ({64'd0, num} << 16) / {64'd0, den};
         value = wide[31:0];
      end
      return (value > cap) ? cap : value;
   endfunction

   function automatic void compute_features(req_type s, output logic [31:0] f [FEATURE_COUNT]);
      logic [63:0] thr, mx, mn;
      thr = 64'(s.avg_throughput);
      mx  = 64'(s.max_throughput);
      mn  = 64'(s.minimum_rtt);
      if (thr == 0)
         f[0] = Q_HALF;
      else
         f[0] = (mx != 0) ? q16_quotient(thr, mx, Q_SAT) : Q_ZERO;
      if (s.avg_unsmoothed_rtt == 0)
         f[1] = Q_TWO;
      else
         f[1] = (mn != 0) ? q16_quotient(64'(s.avg_unsmoothed_rtt), mn, Q_TWO) : Q_ZERO;
      if (s.smoothed_rtt_x8 == 0)
         f[2] = Q_TWO;
      else
         f[2] = (mn != 0) ? q16_quotient(64'(s.smoothed_rtt_x8), mn * 8, Q_TWO) : Q_ZERO;
      if (mn == 0 || mx == 0)
         f[3] = Q_ZERO;
      else
         f[3] = q16_quotient(64'(s.congestion_window) * 64'(F3_SCALE), mn * mx, Q_TWO);
      f[4] = q16_quotient(mx, F4_DIVSOR, Q_SAT);
      f[5] = q16_quotient(mn, F5_DIVSOR, Q_SAT);
      f[6] = (mx != 0) ? q16_quotient(64'(s.loss_fraction), mx << 16, Q_SAT) : Q_ZERO;
      f[7] = q16_quotient(64'(s.packets_in_flight), 64'(s.congestion_window), Q_SAT);
      f[8] = (mx != 0) ? q16_quotient(64'(s.pacing_rate_in), mx, Q_TWO) : Q_ZERO;
      f[9] = (s.packets_in_flight != 0) ?
             q16_quotient(64'(s.retransmits_out), 64'(s.packets_in_flight), Q_SAT) :
             Q_ZERO;
   endfunction

   // Shift the new frame into the window and queue all beats of the window.
   task automatic queue_window_beats(logic [31:0] f [FEATURE_COUNT]);
      rsp_type beat;
      for (int k = 0; k < WINDOW_LEN - FEATURE_COUNT; k++)
         window_model[k] = window_model[k + FEATURE_COUNT];
      for (int k = 0; k < FEATURE_COUNT; k++)
         window_model[WINDOW_LEN - FEATURE_COUNT + k] = f[k];
      for (int k = 0; k < WINDOW_LEN; k++) begin
         beat.feature_value   = window_model[k];
         beat.window_position = 6'(k);
         beat.last_value      = (k == WINDOW_LEN - 1);
         pending_beats = {pending_beats, beat};
      end
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 16);
         3: return $urandom_range(1, 2000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_sample();
      req_type s;
      s.avg_throughput     = rand_word();
      s.avg_unsmoothed_rtt = rand_word();
      s.smoothed_rtt_x8    = rand_word();
      s.minimum_rtt        = rand_word();
      s.max_throughput     = rand_word();
      s.congestion_window  = rand_word();
      s.packets_in_flight  = rand_word();
      s.pacing_rate_in     = rand_word();
      s.retransmits_out    = rand_word();
      // Loss both within one and above it, so all 17 bits toggle.
      case ($urandom_range(0, 3))
         0: s.loss_fraction = 17'h1FFFF;
         1: s.loss_fraction = 17'($urandom_range(0, 65536));
         default: s.loss_fraction = 17'($urandom);
      endcase
      return s;
   endfunction

   function automatic req_type typical_sample();
      req_type s;
      s.avg_throughput     = 32'd50000;
      s.avg_unsmoothed_rtt = 32'd12000;
      s.smoothed_rtt_x8    = 32'd96000;
      s.minimum_rtt        = 32'd10000;
      s.max_throughput     = 32'd100000;
      s.congestion_window  = 32'd40;
      s.packets_in_flight  = 32'd30;
      s.pacing_rate_in     = 32'd90000;
      s.retransmits_out    = 32'd3;
      s.loss_fraction      = 17'd655;
      return s;
   endfunction

   function automatic void add_row(req_type s, bit known, logic [31:0] f [FEATURE_COUNT]);
      row_type r;
      r.sample       = s;
      r.has_expected = known;
      r.features     = f;
      directed_rows  = {directed_rows, r};
   endfunction

   // Directed table: extremes of every field and each zero-divisor rule.
   task automatic build_directed_rows();
      req_type     s;
      logic [31:0] f [FEATURE_COUNT];
      logic [31:0] none [FEATURE_COUNT];
      foreach (none[k]) none[k] = '0;
      // All fields zero: every zero rule fires at once, cwnd of zero saturates f7.
      s = '0;
      f = '{Q_HALF, Q_TWO, Q_TWO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_SAT, Q_ZERO, Q_ZERO};
      add_row(s, 1, f);
      // All fields at their maximum.
      s = '1;
      f = '{32'h0001_0000, 32'h0001_0000, 32'h0000_2000, Q_ZERO, 32'h01AD_7F29,
            32'h218D_EF41, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      f[3] = q16_quotient(64'hFFFF_FFFF * 64'(F3_SCALE), 64'hFFFF_FFFF * 64'hFFFF_FFFF, Q_TWO);
      f[6] = q16_quotient(64'h1FFFF, 64'hFFFF_FFFF << 16, Q_SAT);
      f[4] = q16_quotient(64'hFFFF_FFFF, F4_DIVSOR, Q_SAT);
      f[5] = q16_quotient(64'hFFFF_FFFF, F5_DIVSOR, Q_SAT);
      add_row(s, 1, f);
      // Zero minimum RTT with nonzero RTT samples.
      s = typical_sample();
      s.minimum_rtt = 0;
      add_row(s, 0, none);
      // Zero max throughput with a throughput measurement.
      s = typical_sample();
      s.max_throughput = 0;
      add_row(s, 0, none);
      // No throughput measurement.
      s = typical_sample();
      s.avg_throughput = 0;
      add_row(s, 0, none);
      // Zero congestion window with packets in flight.
      s = typical_sample();
      s.congestion_window = 0;
      add_row(s, 0, none);
      // Zero packets in flight.
      s = typical_sample();
      s.packets_in_flight = 0;
      add_row(s, 0, none);
      // Zero RTT samples give the clamp value.
      s = typical_sample();
      s.avg_unsmoothed_rtt = 0;
      s.smoothed_rtt_x8    = 0;
      add_row(s, 0, none);
      // Loss above one, and ratios that hit the clamp at two.
      s = typical_sample();
      s.loss_fraction      = 17'h1FFFF;
      s.pacing_rate_in     = 32'hFFFF_FFFF;
      s.avg_unsmoothed_rtt = 32'hFFFF_FFFF;
      s.minimum_rtt        = 32'd1;
      add_row(s, 0, none);
      // Quotient overflow saturates.
      s = typical_sample();
      s.avg_throughput   = 32'hFFFF_FFFF;
      s.max_throughput   = 32'd1;
      s.retransmits_out  = 32'hFFFF_FFFF;
      s.packets_in_flight = 32'd1;
      add_row(s, 0, none);
      s = typical_sample();
      add_row(s, 0, none);
      for (int k = 0; k < 6; k++)
         add_row(random_sample(), 0, none);
   endtask

   // Offer one sample; holds push until the beat is accepted.
   task automatic send_sample(req_type s);
      logic [31:0] f [FEATURE_COUNT];
      push     <= 1'b1;
      req_data <= s;
      do
         @(posedge clock);
      while (full);
      compute_features(s, f);
      queue_window_beats(f);
   endtask

   // Sender: directed table, then random samples in bursts with gaps.
   initial begin
      logic [31:0] f [FEATURE_COUNT];
      int burst;
      push      = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      stim_done = 0;
      foreach (window_model[k]) window_model[k] = '0;
      build_directed_rows();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[r]) begin
         send_sample(directed_rows[r].sample);
         if (directed_rows[r].has_expected) begin
            compute_features(directed_rows[r].sample, f);
            foreach (f[k])
               if (f[k] !== directed_rows[r].features[k])
                  $display("table row %0d feature %0d: predictor %h, table %h",
                           r, k, f[k], directed_rows[r].features[k]);
            // The table value is what the newest frame must carry.
            for (int k = 0; k < FEATURE_COUNT; k++)
               pending_beats[pending_beats.size() - FEATURE_COUNT + k].feature_value =
                  directed_rows[r].features[k];
         end
         if ($urandom_range(0, 1)) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++)
            send_sample(random_sample());
         // Some bursts run back to back, others leave a gap.
         if ($urandom_range(0, 2) != 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 600)) @(posedge clock);
         end
      end
      push      <= 1'b0;
      stim_done = 1;
   end

   // Receiver: its own stall pattern, plus one long hold-off early in the run
   // so the result side backs up and the input side sees full.
   initial begin
      hold_off = 0;
      @(negedge reset);
      repeat (50) @(posedge clock);
      hold_off = 1;
      repeat (6000) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      if (reset || hold_off)
         pop <= 1'b0;
      else if (($urandom_range(0, 255) < 64) && $urandom_range(0, 3) == 0)
         pop <= 1'b0;
      else
         pop <= ($urandom_range(0, 9) != 0);
   end

   // Result checker: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat %p", rsp_data);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"beat mismatch: expected value %h pos %0d last %b, ",
                            "got %h pos %0d last %b"},
                           want.feature_value, want.window_position, want.last_value,
                           rsp_data.feature_value, rsp_data.window_position,
                           rsp_data.last_value);
            end
         end
      end
   end

   // Watchdog on cycles with no accepted beat on either side, and the run's end.
   initial begin
      int idle_cycles;
      bit timed_out;
      mismatch_count = 0;
      idle_cycles    = 0;
      timed_out      = 0;
      @(negedge reset);
      while (!(stim_done && pending_beats.size() == 0) && !timed_out) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT)
            timed_out = 1;
      end
      if (!timed_out) begin
         // Let a stray extra beat show up if the block produces one.
         repeat (500) @(posedge clock);
      end
      if (!timed_out && mismatch_count == 0 && pending_beats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fwb_pkg.sv
rtl/fwb_front.sv
rtl/fwb_queue.sv
rtl/fwb_divider.sv
rtl/fwb_back.sv
rtl/tcp_feature_window_builder.sv
verif/tb_tcp_feature_window_builder.sv
